FILE: hw/rtl/snell_refraction_vector_core_defines.svh
// Assertion macros used by the checker of the refraction core.
`ifndef SNELL_REFRACTION_VECTOR_CORE_DEFINES_SVH
`define SNELL_REFRACTION_VECTOR_CORE_DEFINES_SVH

// Plain implication, checked at every rising clock edge outside reset.
`define SRV_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("refraction core assertion failed");

// Implication with a delay, given by argument n, before the consequent.
`define SRV_ASSERT_DELAY(lbl, clk, rst, ante, n, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ## (n) (cons)) \
      else $error("refraction core assertion failed");

`endif

FILE: hw/rtl/srv_pkg.sv
// Shared types and constants of the refraction core.
package srv_pkg;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_TIR  = 2'd1,
      STATUS_ZERO = 2'd2
   } status_type;

   localparam int NORM_GUARD = 8;

endpackage

FILE: hw/rtl/srv_isqrt.sv
// Pipelined integer square root, one root bit per stage, with remainder.
module srv_isqrt #(
   parameter int IW    = 48,
   parameter int SIDEW = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [IW-1:0]    in_radicand,
   input  logic [SIDEW-1:0] in_side,
   output logic             out_valid,
   output logic [IW/2-1:0]  out_root,
   output logic [IW/2+1:0]  out_rem,
   output logic [SIDEW-1:0] out_side
);

   localparam int RW = IW / 2;

   logic             v_ff    [RW];
   logic [RW-1:0]    root_ff [RW];
   logic [RW+1:0]    rem_ff  [RW];
   logic [IW-1:0]    x_ff    [RW];
   logic [SIDEW-1:0] side_ff [RW];

   for (genvar j = 0; j < RW; j++) begin : g_stage
      logic             pv;
      logic [RW-1:0]    proot;
      logic [RW+1:0]    prem;
      logic [IW-1:0]    px;
      logic [SIDEW-1:0] pside;
      logic [RW+1:0]    cur_in;
      logic [RW+1:0]    trial_in;
      logic             ge_in;

      if (j == 0) begin : g_first
         assign pv    = in_valid;
         assign proot = '0;
         assign prem  = '0;
         assign px    = in_radicand;
         assign pside = in_side;
      end else begin : g_next
         assign pv    = v_ff[j-1];
         assign proot = root_ff[j-1];
         assign prem  = rem_ff[j-1];
         assign px    = x_ff[j-1];
         assign pside = side_ff[j-1];
      end

      assign cur_in   = {prem[RW-1:0], px[IW-1 -: 2]};
      assign trial_in = {proot, 2'b01};
      assign ge_in    = (cur_in >= trial_in);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else begin
            v_ff[j] <= pv;
         end
      end

      always_ff @(posedge clock) begin
         root_ff[j] <= {proot[RW-2:0], ge_in};
         rem_ff[j]  <= ge_in ? (cur_in - trial_in) : cur_in;
         x_ff[j]    <= px << 2;
         side_ff[j] <= pside;
      end
   end

   assign out_valid = v_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_rem   = rem_ff[RW-1];
   assign out_side  = side_ff[RW-1];

endmodule

FILE: hw/rtl/srv_vdiv.sv
// Pipelined restoring divider, three lanes over one shared divisor.
module srv_vdiv #(
   parameter int NW    = 37,
   parameter int DVW   = 24,
   parameter int QW    = 13,
   parameter int SIDEW = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [NW-1:0]    in_num [3],
   input  logic [DVW-1:0]   in_den,
   input  logic [SIDEW-1:0] in_side,
   output logic             out_valid,
   output logic [QW-1:0]    out_quot [3],
   output logic [SIDEW-1:0] out_side
);

   localparam int EW = ((NW > DVW + QW - 1) ? NW : (DVW + QW - 1)) + 1;

   logic             v_ff    [QW];
   logic [NW-1:0]    rem_ff  [QW][3];
   logic [QW-1:0]    quot_ff [QW][3];
   logic [DVW-1:0]   den_ff  [QW];
   logic [SIDEW-1:0] side_ff [QW];

   for (genvar j = 0; j < QW; j++) begin : g_stage
      localparam int SH = QW - 1 - j;
      logic             pv;
      logic [NW-1:0]    prem  [3];
      logic [QW-1:0]    pquot [3];
      logic [DVW-1:0]   pden;
      logic [SIDEW-1:0] pside;
      logic [EW-1:0]    dsh_in;
      logic [2:0]       ge_in;

      if (j == 0) begin : g_first
         assign pv    = in_valid;
         assign prem  = in_num;
         assign pquot = '{default: '0};
         assign pden  = in_den;
         assign pside = in_side;
      end else begin : g_next
         assign pv    = v_ff[j-1];
         assign prem  = rem_ff[j-1];
         assign pquot = quot_ff[j-1];
         assign pden  = den_ff[j-1];
         assign pside = side_ff[j-1];
      end

      assign dsh_in = EW'(pden) << SH;

      always_comb begin
         for (int l = 0; l < 3; l++) begin
            ge_in[l] = (EW'(prem[l]) >= dsh_in);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else begin
            v_ff[j] <= pv;
         end
      end

      always_ff @(posedge clock) begin
         for (int l = 0; l < 3; l++) begin
            rem_ff[j][l]  <= ge_in[l] ? NW'(EW'(prem[l]) - dsh_in) : prem[l];
            quot_ff[j][l] <= {pquot[l][QW-2:0], ge_in[l]};
         end
         den_ff[j]  <= pden;
         side_ff[j] <= pside;
      end
   end

   assign out_valid = v_ff[QW-1];
   assign out_quot  = quot_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule

FILE: hw/rtl/snell_refraction_vector_core.sv
// Snell refraction core: normalize, dot, discriminant, root, refracted vector.
//
//   channel   ports                      handshake
//   request   req_dir_*, req_norm_*,     start high, busy low at the edge
//             req_index_ratio
//   response  rsp_out_*, rsp_status      rsp_valid strobe, one cycle
//
// One word enters per cycle outside reset; its path runs through the two
// root pipelines (one bit a stage) and the divider (one quotient bit a stage).
// Synchronous reset clears all valid bits; busy is high only during reset.
// The response side cannot stall, so the pipeline never holds.
module snell_refraction_vector_core #(
   parameter int COMP_WIDTH = 16,
   parameter int FRAC_BITS  = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COMP_WIDTH-1:0] req_dir_x,
   input  logic signed [COMP_WIDTH-1:0] req_dir_y,
   input  logic signed [COMP_WIDTH-1:0] req_dir_z,
   input  logic signed [COMP_WIDTH-1:0] req_norm_x,
   input  logic signed [COMP_WIDTH-1:0] req_norm_y,
   input  logic signed [COMP_WIDTH-1:0] req_norm_z,
   input  logic        [COMP_WIDTH-1:0] req_index_ratio,
   output logic                         rsp_valid,
   output logic signed [COMP_WIDTH-1:0] rsp_out_x,
   output logic signed [COMP_WIDTH-1:0] rsp_out_y,
   output logic signed [COMP_WIDTH-1:0] rsp_out_z,
   output srv_pkg::status_type          rsp_status
);

   localparam int CW   = COMP_WIDTH;
   localparam int FB   = FRAC_BITS;
   localparam int RF   = CW - 2;
   localparam int G    = srv_pkg::NORM_GUARD;
   localparam int SW   = CW + G;
   localparam int IW1  = 2 * CW + 2 * G;
   localparam int NW   = CW + FB + G + 1;
   localparam int QW   = FB + 1;
   localparam int DW   = FB + 2;
   localparam int PRW  = DW + CW;
   localparam int AW   = PRW + 2;
   localparam int DLW  = AW - FB + 1;
   localparam int DDW  = 2 * DLW;
   localparam int OMW  = ((DDW > 2 * FB + 1) ? DDW : (2 * FB + 1)) + 1;
   localparam int LOW  = OMW / 2;
   localparam int HIW  = OMW - LOW;
   localparam int R2S  = 2 * RF - 2 * FB;
   localparam int R2SM = (R2S > 0) ? (R2S - 1) : 0;
   localparam int R2W  = 2 * CW - R2S + 1;
   localparam int R2SW = R2W + 1;
   localparam int PHW  = R2SW + HIW;
   localparam int PLW  = R2SW + LOW + 1;
   localparam int PW   = R2SW + OMW + 1;
   localparam int TW   = PW + 1 - 2 * FB;
   localparam int DSW  = ((TW > 2 * FB + 2) ? TW : (2 * FB + 2)) + 1;
   localparam int IW2  = (DSW / 2) * 2;
   localparam int SQW  = IW2 / 2;
   localparam int SQRW = SQW + 1;
   localparam int NDW  = CW + DLW;
   localparam int SNW  = CW + SQRW + 1;
   localparam int TIW  = ((DW + FB > NDW) ? (DW + FB) : NDW) + 1;
   localparam int RTW  = CW + 1 + TIW;
   localparam int VW   = ((RTW > SNW + RF) ? RTW : (SNW + RF)) + 1;
   localparam int OW   = VW + 1 - FB - RF;
   localparam int LATENCY = 2 + SW + 1 + QW + 9 + SQW + 5;

   localparam logic [2*CW:0]         R2H    = (R2S > 0) ? ((2*CW+1)'(1) << R2SM) : '0;
   localparam logic [AW:0]           D_HALF = (AW+1)'(1) << (FB - 1);
   localparam logic [PW:0]           T_HALF = (PW+1)'(1) << (2 * FB - 1);
   localparam logic [VW:0]           V_HALF = (VW+1)'(1) << (FB + RF - 1);
   localparam logic signed [OMW-1:0] ONE_OM = OMW'(1) << (2 * FB);
   localparam logic signed [DSW-1:0] ONE_DS = DSW'(1) << (2 * FB);
   localparam logic signed [OW-1:0]  SAT_HI = {{(OW-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [OW-1:0]  SAT_LO = ~SAT_HI;

   typedef struct packed {
      logic [2:0][CW-1:0] dir;
      logic [2:0][CW-1:0] norm;
      logic [CW-1:0]      ratio;
      logic [R2W-1:0]     r2;
      logic               zero;
   } s1_type;

   typedef struct packed {
      logic [2:0]         neg;
      logic [2:0][CW-1:0] norm;
      logic [CW-1:0]      ratio;
      logic [R2W-1:0]     r2;
      logic               zero;
   } s2_type;

   typedef struct packed {
      logic [2:0][DW-1:0]     u;
      logic [2:0][CW-1:0]     norm;
      logic [CW-1:0]          ratio;
      logic [R2W-1:0]         r2;
      logic                   zero;
      logic signed [DLW-1:0]  dval;
   } dc_type;

   typedef struct packed {
      logic [2:0][DW-1:0]    u;
      logic [2:0][CW-1:0]    norm;
      logic signed [DLW-1:0] dval;
      logic [CW-1:0]         ratio;
      srv_pkg::status_type   status;
   } s3_type;

   logic accept;
   assign busy   = reset;
   assign accept = start && !busy;

   // stage A: capture, squares
   logic signed [CW-1:0] dir_in [3];
   assign dir_in[0] = req_dir_x;
   assign dir_in[1] = req_dir_y;
   assign dir_in[2] = req_dir_z;

   logic                 a_v_ff;
   logic [2:0][CW-1:0]   a_dir_ff;
   logic [2:0][CW-1:0]   a_norm_ff;
   logic [CW-1:0]        a_ratio_ff;
   logic [2*CW-1:0]      a_sq_ff [3];
   logic [2*CW-1:0]      a_rr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else begin
         a_v_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      a_dir_ff   <= {req_dir_z, req_dir_y, req_dir_x};
      a_norm_ff  <= {req_norm_z, req_norm_y, req_norm_x};
      a_ratio_ff <= req_index_ratio;
      a_rr_ff    <= req_index_ratio * req_index_ratio;
      for (int i = 0; i < 3; i++) begin
         a_sq_ff[i] <= (2*CW)'(dir_in[i] * dir_in[i]);
      end
   end

   // stage B: squared length, squared ratio
   logic         b_v_ff;
   s1_type       b_side_ff;
   logic [2*CW-1:0] b_l2_ff;
   logic [2*CW-1:0] l2_in;

   assign l2_in = a_sq_ff[0] + a_sq_ff[1] + a_sq_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else begin
         b_v_ff <= a_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_l2_ff          <= l2_in;
      b_side_ff.dir    <= a_dir_ff;
      b_side_ff.norm   <= a_norm_ff;
      b_side_ff.ratio  <= a_ratio_ff;
      b_side_ff.r2     <= R2W'(({1'b0, a_rr_ff} + R2H) >> R2S);
      b_side_ff.zero   <= (l2_in == '0);
   end

   // length root
   logic          s1_v;
   logic [SW-1:0] s1_root;
   logic [SW+1:0] s1_rem;
   s1_type        s1_side;

   srv_isqrt #(
      .IW    (IW1),
      .SIDEW ($bits(s1_type))
   ) u_len_sqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (b_v_ff),
      .in_radicand ({b_l2_ff, {(2*G){1'b0}}}),
      .in_side     (b_side_ff),
      .out_valid   (s1_v),
      .out_root    (s1_root),
      .out_rem     (s1_rem),
      .out_side    (s1_side)
   );

   // stage C: numerators for normalization
   logic          c_v_ff;
   logic [NW-1:0] c_num_ff [3];
   logic [SW-1:0] c_den_ff;
   s2_type        c_side_ff;
   logic          len_unused;

   assign len_unused = ^s1_rem;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else begin
         c_v_ff <= s1_v && !(len_unused && 1'b0);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         logic [CW-1:0] mag;
         mag = s1_side.dir[i][CW-1] ? CW'(-s1_side.dir[i]) : s1_side.dir[i];
         c_num_ff[i]     <= NW'({mag, {(FB+G){1'b0}}}) + NW'(s1_root >> 1);
         c_side_ff.neg[i] <= s1_side.dir[i][CW-1];
      end
      c_den_ff        <= s1_root;
      c_side_ff.norm  <= s1_side.norm;
      c_side_ff.ratio <= s1_side.ratio;
      c_side_ff.r2    <= s1_side.r2;
      c_side_ff.zero  <= s1_side.zero;
   end

   // normalization divide
   logic          dv_out_v;
   logic [QW-1:0] dv_quot [3];
   s2_type        dv_side;

   srv_vdiv #(
      .NW    (NW),
      .DVW   (SW),
      .QW    (QW),
      .SIDEW ($bits(s2_type))
   ) u_norm_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_v_ff),
      .in_num    (c_num_ff),
      .in_den    (c_den_ff),
      .in_side   (c_side_ff),
      .out_valid (dv_out_v),
      .out_quot  (dv_quot),
      .out_side  (dv_side)
   );

   // stages D1..D9: dot product, discriminant
   logic                  dv_ff [9];
   dc_type                dc_ff [9];
   dc_type                dc0_in;
   dc_type                dc2_in;
   logic signed [PRW-1:0] d1_prod_ff [3];
   logic signed [AW-1:0]  d2_acc_ff;
   logic signed [DDW-1:0] d4_dd_ff;
   logic signed [OMW-1:0] d5_om_ff;
   logic signed [PHW-1:0] d6_ph_ff;
   logic signed [PLW-1:0] d6_pl_ff;
   logic signed [PW-1:0]  d7_p_ff;
   logic signed [TW-1:0]  d8_t_ff;
   logic [IW2-1:0]        d9_rad_ff;
   srv_pkg::status_type   d9_status_ff;

   logic [AW:0]           d_sum_in;
   logic [PW:0]           t_sum_in;
   logic signed [DSW-1:0] disc_in;
   logic                  disc_pos_in;

   always_comb begin
      dc0_in       = '0;
      dc0_in.norm  = dv_side.norm;
      dc0_in.ratio = dv_side.ratio;
      dc0_in.r2    = dv_side.r2;
      dc0_in.zero  = dv_side.zero;
      for (int i = 0; i < 3; i++) begin
         dc0_in.u[i] = dv_side.neg[i] ? DW'(-$signed({1'b0, dv_quot[i]}))
                                      : DW'($signed({1'b0, dv_quot[i]}));
      end
   end

   assign d_sum_in = {d2_acc_ff[AW-1], d2_acc_ff}
                   + (d2_acc_ff[AW-1] ? (D_HALF - 1'b1) : D_HALF);
   assign t_sum_in = {d7_p_ff[PW-1], d7_p_ff}
                   + (d7_p_ff[PW-1] ? (T_HALF - 1'b1) : T_HALF);
   assign disc_in     = ONE_DS - DSW'(d8_t_ff);
   assign disc_pos_in = !disc_in[DSW-1] && (disc_in != '0);

   always_comb begin
      dc2_in      = dc_ff[1];
      dc2_in.dval = $signed(d_sum_in[AW:FB]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 9; k++) begin
            dv_ff[k] <= 1'b0;
         end
      end else begin
         dv_ff[0] <= dv_out_v;
         for (int k = 1; k < 9; k++) begin
            dv_ff[k] <= dv_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      dc_ff[0] <= dc0_in;
      dc_ff[1] <= dc_ff[0];
      dc_ff[2] <= dc2_in;
      for (int k = 3; k < 9; k++) begin
         dc_ff[k] <= dc_ff[k-1];
      end
      for (int i = 0; i < 3; i++) begin
         d1_prod_ff[i] <= $signed(dc0_in.u[i]) * $signed(dc0_in.norm[i]);
      end
      d2_acc_ff <= AW'(d1_prod_ff[0]) + AW'(d1_prod_ff[1]) + AW'(d1_prod_ff[2]);
      d4_dd_ff  <= dc_ff[2].dval * dc_ff[2].dval;
      d5_om_ff  <= ONE_OM - OMW'(d4_dd_ff);
      d6_ph_ff  <= $signed({1'b0, dc_ff[4].r2}) * $signed(d5_om_ff[OMW-1:LOW]);
      d6_pl_ff  <= $signed({1'b0, dc_ff[4].r2}) * $signed({1'b0, d5_om_ff[LOW-1:0]});
      d7_p_ff   <= (PW'(d6_ph_ff) <<< LOW) + PW'(d6_pl_ff);
      d8_t_ff   <= $signed(t_sum_in[PW:2*FB]);
      d9_rad_ff <= disc_pos_in ? IW2'(disc_in[DSW-2:0]) : '0;
      priority if (dc_ff[7].zero) begin
         d9_status_ff <= srv_pkg::STATUS_ZERO;
      end else if (!disc_pos_in) begin
         d9_status_ff <= srv_pkg::STATUS_TIR;
      end else begin
         d9_status_ff <= srv_pkg::STATUS_OK;
      end
   end

   // discriminant root
   s3_type s3_in;
   always_comb begin
      s3_in.u      = dc_ff[8].u;
      s3_in.norm   = dc_ff[8].norm;
      s3_in.dval   = dc_ff[8].dval;
      s3_in.ratio  = dc_ff[8].ratio;
      s3_in.status = d9_status_ff;
   end

   logic           s3_v;
   logic [SQW-1:0] s3_root;
   logic [SQW+1:0] s3_rem;
   s3_type         s3_side;

   srv_isqrt #(
      .IW    (IW2),
      .SIDEW ($bits(s3_type))
   ) u_disc_sqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (dv_ff[8]),
      .in_radicand (d9_rad_ff),
      .in_side     (s3_in),
      .out_valid   (s3_v),
      .out_root    (s3_root),
      .out_rem     (s3_rem),
      .out_side    (s3_side)
   );

   // stages F1..F5: refracted vector
   logic [SQRW-1:0] sq_in;
   assign sq_in = SQRW'(s3_root) + SQRW'(s3_rem > (SQW+2)'(s3_root));

   logic                  fv_ff [5];
   logic signed [NDW-1:0] f1_nd_ff [3];
   logic signed [SNW-1:0] f1_sn_ff [3];
   logic signed [DW-1:0]  f1_u_ff  [3];
   logic signed [TIW-1:0] f2_t_ff  [3];
   logic signed [SNW-1:0] f2_sn_ff [3];
   logic signed [RTW-1:0] f3_rt_ff [3];
   logic signed [SNW-1:0] f3_sn_ff [3];
   logic signed [VW-1:0]  f4_v_ff  [3];
   logic signed [CW-1:0]  f5_out_ff [3];
   logic [CW-1:0]         f1_ratio_ff;
   logic [CW-1:0]         f2_ratio_ff;
   srv_pkg::status_type   f_status_ff [5];
   logic [VW:0]           o_sum_in [3];
   logic signed [OW-1:0]  o_rnd_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         o_sum_in[i] = {f4_v_ff[i][VW-1], f4_v_ff[i]}
                     + (f4_v_ff[i][VW-1] ? (V_HALF - 1'b1) : V_HALF);
         o_rnd_in[i] = $signed(o_sum_in[i][VW:FB+RF]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 5; k++) begin
            fv_ff[k] <= 1'b0;
         end
      end else begin
         fv_ff[0] <= s3_v;
         for (int k = 1; k < 5; k++) begin
            fv_ff[k] <= fv_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      f_status_ff[0] <= s3_side.status;
      for (int k = 1; k < 5; k++) begin
         f_status_ff[k] <= f_status_ff[k-1];
      end
      f1_ratio_ff <= s3_side.ratio;
      f2_ratio_ff <= f1_ratio_ff;
      for (int i = 0; i < 3; i++) begin
         f1_nd_ff[i] <= $signed(s3_side.norm[i]) * s3_side.dval;
         f1_sn_ff[i] <= $signed(s3_side.norm[i]) * $signed({1'b0, sq_in});
         f1_u_ff[i]  <= $signed(s3_side.u[i]);
         f2_t_ff[i]  <= (TIW'(f1_u_ff[i]) <<< FB) - TIW'(f1_nd_ff[i]);
         f2_sn_ff[i] <= f1_sn_ff[i];
         f3_rt_ff[i] <= $signed({1'b0, f2_ratio_ff}) * f2_t_ff[i];
         f3_sn_ff[i] <= f2_sn_ff[i];
         f4_v_ff[i]  <= VW'(f3_rt_ff[i]) - (VW'(f3_sn_ff[i]) <<< RF);
         priority if (f_status_ff[3] != srv_pkg::STATUS_OK) begin
            f5_out_ff[i] <= '0;
         end else if (o_rnd_in[i] > SAT_HI) begin
            f5_out_ff[i] <= SAT_HI[CW-1:0];
         end else if (o_rnd_in[i] < SAT_LO) begin
            f5_out_ff[i] <= SAT_LO[CW-1:0];
         end else begin
            f5_out_ff[i] <= o_rnd_in[i][CW-1:0];
         end
      end
   end

   assign rsp_valid  = fv_ff[4];
   assign rsp_out_x  = f5_out_ff[0];
   assign rsp_out_y  = f5_out_ff[1];
   assign rsp_out_z  = f5_out_ff[2];
   assign rsp_status = f_status_ff[4];

endmodule

FILE: hw/rtl/srv_checker.sv
// Port-level checks of the refraction core, bound to the top level.
`include "snell_refraction_vector_core_defines.svh"

module srv_checker #(
   parameter int CW      = 16,
   parameter int LATENCY = 80
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic [CW-1:0]        req_dir_x,
   input logic [CW-1:0]        req_dir_y,
   input logic [CW-1:0]        req_dir_z,
   input logic                 rsp_valid,
   input logic [CW-1:0]        rsp_out_x,
   input logic [CW-1:0]        rsp_out_y,
   input logic [CW-1:0]        rsp_out_z,
   input srv_pkg::status_type  rsp_status
);

   logic accept;
   logic dir_zero;

   assign accept   = start && !busy;
   assign dir_zero = (req_dir_x == '0) && (req_dir_y == '0) && (req_dir_z == '0);

   `SRV_ASSERT_DELAY(a_word_arrives, clock, reset, accept, LATENCY, rsp_valid)
   `SRV_ASSERT_IMPLY(a_no_orphan, clock, reset, rsp_valid, $past(accept, LATENCY))
   `SRV_ASSERT_DELAY(a_zero_dir, clock, reset, accept && dir_zero, LATENCY, rsp_status == srv_pkg::STATUS_ZERO)
   `SRV_ASSERT_IMPLY(a_quiet_vector, clock, reset, rsp_valid && (rsp_status != srv_pkg::STATUS_OK), (rsp_out_x == '0) && (rsp_out_y == '0) && (rsp_out_z == '0))

endmodule

bind snell_refraction_vector_core srv_checker #(
   .CW      (COMP_WIDTH),
   .LATENCY (LATENCY)
) u_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_dir_x  (req_dir_x),
   .req_dir_y  (req_dir_y),
   .req_dir_z  (req_dir_z),
   .rsp_valid  (rsp_valid),
   .rsp_out_x  (rsp_out_x),
   .rsp_out_y  (rsp_out_y),
   .rsp_out_z  (rsp_out_z),
   .rsp_status (rsp_status)
);
